// ----- sv/coincidence_time_histogram_unit_assert.svh -----
// Assertion macros shared by the coincidence time histogram RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef COINCIDENCE_TIME_HISTOGRAM_UNIT_ASSERT_SVH
`define COINCIDENCE_TIME_HISTOGRAM_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cth_pkg.sv -----
// Package for the coincidence time histogram unit: sizes, codes, types and
// the bin address function. Used by the sequencer and the top level.
package cth_pkg;

    localparam int REF_DEPTH = 256;
    localparam int CHANNELS  = 8;
    localparam int BINS      = 2048;

    localparam int FUNC_W     = 3;
    localparam int TS_W       = 32;
    localparam int TICK_W     = 12;
    localparam int CH_W       = 3;
    localparam int BIN_W      = 11;
    localparam int VAL_W      = 32;
    localparam int WIN_W      = 24;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int T_W        = TS_W + TICK_W;
    localparam int DT_W       = T_W + 1;

    localparam int REF_AW        = $clog2(REF_DEPTH);
    localparam int CNT_W         = $clog2(REF_DEPTH + 1);
    localparam int BIN_MEM_DEPTH = CHANNELS * BINS;
    localparam int BIN_MEM_AW    = $clog2(BIN_MEM_DEPTH);

    localparam logic [TICK_W-1:0]  REF_TICK_RST  = TICK_W'(16);
    localparam logic [WIN_W-1:0]   WIN_LOW_RST   = WIN_W'(-320000);
    localparam logic [WIN_W-1:0]   WIN_HIGH_RST  = WIN_W'(320000);
    localparam logic [SHIFT_W-1:0] BIN_SHIFT_RST = SHIFT_W'(9);

    typedef enum logic [FUNC_W-1:0] {
        F_CLR_REFS = 3'd0,
        F_LOAD_REF = 3'd1,
        F_RESTART  = 3'd2,
        F_PULSE    = 3'd3,
        F_READ_BIN = 3'd4,
        F_CLR_BIN  = 3'd5
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_TICK  = 2'd0,
        CFG_WIN_LOW   = 2'd1,
        CFG_WIN_HIGH  = 2'd2,
        CFG_BIN_SHIFT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0]  ref_tick;
        logic [WIN_W-1:0]   window_low;
        logic [WIN_W-1:0]   window_high;
        logic [SHIFT_W-1:0] bin_shift;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [REF_AW-1:0] addr;
        logic [T_W-1:0]    wdata;
    } t_ref_req;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [BIN_MEM_AW-1:0] addr;
        logic [VAL_W-1:0]      wdata;
    } t_bin_req;

    function automatic logic [BIN_MEM_AW-1:0] bin_addr(input logic [CH_W-1:0] ch,
                                                       input logic [WIN_W-1:0] idx);
        bin_addr = BIN_MEM_AW'(ch) * BIN_MEM_AW'(BINS) + BIN_MEM_AW'(idx);
    endfunction

endpackage

// ----- sv/cth_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Used for the reference store and the bin store.
module cth_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 44
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cth_seq.sv -----
// Command sequencer of the coincidence time histogram unit: reference loads,
// the reference walk and the bin read-modify-write. Depends on cth_pkg.
`include "coincidence_time_histogram_unit_assert.svh"

module cth_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [cth_pkg::FUNC_W-1:0]   i_func,
    input  logic [cth_pkg::TS_W-1:0]     i_timestamp,
    input  logic [cth_pkg::TICK_W-1:0]   i_tick,
    input  logic [cth_pkg::CH_W-1:0]     i_channel,
    input  logic [cth_pkg::BIN_W-1:0]    i_bin,
    input  cth_pkg::t_cfg                i_cfg,
    output cth_pkg::t_ref_req            o_ref_req,
    input  logic [cth_pkg::T_W-1:0]      i_ref_rdata,
    output cth_pkg::t_bin_req            o_bin_req,
    input  logic [cth_pkg::VAL_W-1:0]    i_bin_rdata,
    output logic                         o_done,
    output logic [cth_pkg::VAL_W-1:0]    o_value,
    output logic                         o_flag
);

    typedef enum logic [9:0] {
        S_CLR  = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_EXEC = 10'b0000000100,
        S_LDWR = 10'b0000001000,
        S_WRD  = 10'b0000010000,
        S_WDIF = 10'b0000100000,
        S_WCMP = 10'b0001000000,
        S_WBIN = 10'b0010000000,
        S_WINC = 10'b0100000000,
        S_RDW  = 10'b1000000000
    } t_state;

    t_state                             r_state, n_state;
    logic [cth_pkg::BIN_MEM_AW-1:0]     r_clr_addr, n_clr_addr;
    logic [cth_pkg::CNT_W-1:0]          r_ref_count, n_ref_count;
    logic [cth_pkg::CNT_W-1:0]          r_scan, n_scan;
    logic                               r_done, n_done;

    cth_pkg::t_func                     r_func, n_func;
    logic [cth_pkg::TS_W-1:0]           r_ts, n_ts;
    logic [cth_pkg::TICK_W-1:0]         r_tick, n_tick;
    logic [cth_pkg::CH_W-1:0]           r_ch, n_ch;
    logic [cth_pkg::WIN_W-1:0]          r_idx, n_idx;
    logic [cth_pkg::T_W-1:0]            r_t, n_t;
    logic [cth_pkg::DT_W-1:0]           r_dt, n_dt;
    logic [cth_pkg::CNT_W-1:0]          r_j, n_j;
    logic [cth_pkg::CNT_W-1:0]          r_fills, n_fills;
    logic                               r_pflag, n_pflag;
    logic [cth_pkg::VAL_W-1:0]          r_value, n_value;
    logic                               r_oflag, n_oflag;

    logic [cth_pkg::DT_W-1:0]           wl_ext;
    logic [cth_pkg::DT_W-1:0]           wh_ext;
    logic                               below_low;
    logic                               below_high;
    logic [cth_pkg::WIN_W-1:0]          offset;
    logic                               ch_ok;
    logic                               bin_ok;
    logic [cth_pkg::TICK_W-1:0]         mult;

    assign wl_ext = {{(cth_pkg::DT_W - cth_pkg::WIN_W){i_cfg.window_low[cth_pkg::WIN_W-1]}},
                     i_cfg.window_low};
    assign wh_ext = {{(cth_pkg::DT_W - cth_pkg::WIN_W){i_cfg.window_high[cth_pkg::WIN_W-1]}},
                     i_cfg.window_high};
    assign below_low  = $signed(r_dt) < $signed(wl_ext);
    assign below_high = $signed(r_dt) < $signed(wh_ext);
    assign offset     = r_dt[cth_pkg::WIN_W-1:0] - i_cfg.window_low;
    assign ch_ok      = int'(r_ch) < cth_pkg::CHANNELS;
    assign bin_ok     = r_idx < cth_pkg::WIN_W'(cth_pkg::BINS);
    assign mult       = (r_func == cth_pkg::F_LOAD_REF) ? i_cfg.ref_tick : r_tick;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ref_count = r_ref_count;
        n_scan      = r_scan;
        n_done      = 1'b0;
        n_func      = r_func;
        n_ts        = r_ts;
        n_tick      = r_tick;
        n_ch        = r_ch;
        n_idx       = r_idx;
        n_t         = r_t;
        n_dt        = r_dt;
        n_j         = r_j;
        n_fills     = r_fills;
        n_pflag     = r_pflag;
        n_value     = r_value;
        n_oflag     = r_oflag;

        o_ref_req       = '0;
        o_ref_req.addr  = r_j[cth_pkg::REF_AW-1:0];
        o_ref_req.wdata = r_t;
        o_bin_req       = '0;
        o_bin_req.addr  = cth_pkg::bin_addr(r_ch, r_idx);

        case (r_state)
            S_CLR: begin
                o_bin_req.we   = 1'b1;
                o_bin_req.addr = r_clr_addr;
                n_clr_addr     = r_clr_addr + 1'b1;
                if (r_clr_addr == cth_pkg::BIN_MEM_AW'(cth_pkg::BIN_MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_func  = cth_pkg::t_func'(i_func);
                    n_ts    = i_timestamp;
                    n_tick  = i_tick;
                    n_ch    = i_channel;
                    n_idx   = cth_pkg::WIN_W'(i_bin);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_t     = cth_pkg::T_W'(r_ts) * cth_pkg::T_W'(mult);
                n_value = cth_pkg::VAL_W'(r_ref_count);
                n_oflag = 1'b0;
                case (r_func)
                    cth_pkg::F_CLR_REFS: begin
                        n_ref_count = '0;
                        n_scan      = '0;
                        n_value     = '0;
                        n_done      = 1'b1;
                        n_state     = S_IDLE;
                    end
                    cth_pkg::F_LOAD_REF: begin
                        n_state = S_LDWR;
                    end
                    cth_pkg::F_RESTART: begin
                        n_scan  = '0;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    cth_pkg::F_PULSE: begin
                        if (ch_ok) begin
                            n_j     = r_scan;
                            n_fills = '0;
                            n_pflag = 1'b0;
                            n_state = S_WRD;
                        end else begin
                            n_value = '0;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    cth_pkg::F_READ_BIN: begin
                        if (ch_ok && bin_ok) begin
                            o_bin_req.re = 1'b1;
                            n_state      = S_RDW;
                        end else begin
                            n_value = '0;
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    cth_pkg::F_CLR_BIN: begin
                        o_bin_req.we = ch_ok && bin_ok;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LDWR: begin
                if (r_ref_count < cth_pkg::CNT_W'(cth_pkg::REF_DEPTH)) begin
                    o_ref_req.we   = 1'b1;
                    o_ref_req.addr = r_ref_count[cth_pkg::REF_AW-1:0];
                    n_ref_count    = r_ref_count + 1'b1;
                    n_value        = cth_pkg::VAL_W'(n_ref_count);
                end else begin
                    n_oflag = 1'b1;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_WRD: begin
                if (r_j < r_ref_count) begin
                    o_ref_req.re = 1'b1;
                    n_state      = S_WDIF;
                end else begin
                    n_value = cth_pkg::VAL_W'(r_fills);
                    n_oflag = r_pflag;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_WDIF: begin
                n_dt    = {1'b0, r_t} - {1'b0, i_ref_rdata};
                n_state = S_WCMP;
            end
            S_WCMP: begin
                if (below_low) begin
                    n_value = cth_pkg::VAL_W'(r_fills);
                    n_oflag = r_pflag;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (below_high) begin
                    n_idx   = offset >> i_cfg.bin_shift;
                    n_state = S_WBIN;
                end else begin
                    n_scan  = r_scan + 1'b1;
                    n_j     = r_j + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WBIN: begin
                if (bin_ok) begin
                    o_bin_req.re = 1'b1;
                    n_state      = S_WINC;
                end else begin
                    n_pflag = 1'b1;
                    n_j     = r_j + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_WINC: begin
                if (i_bin_rdata == '1) begin
                    n_pflag = 1'b1;
                end else begin
                    o_bin_req.we    = 1'b1;
                    o_bin_req.wdata = i_bin_rdata + 1'b1;
                end
                n_fills = r_fills + 1'b1;
                n_j     = r_j + 1'b1;
                n_state = S_WRD;
            end
            S_RDW: begin
                n_value = i_bin_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_ref_count <= '0;
            r_scan      <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_ref_count <= n_ref_count;
            r_scan      <= n_scan;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_ts    <= n_ts;
        r_tick  <= n_tick;
        r_ch    <= n_ch;
        r_idx   <= n_idx;
        r_t     <= n_t;
        r_dt    <= n_dt;
        r_j     <= n_j;
        r_fills <= n_fills;
        r_pflag <= n_pflag;
        r_value <= n_value;
        r_oflag <= n_oflag;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_flag  = r_oflag;

    `CTH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted item did not raise busy")
    `CTH_ASSERT_SAME(a_done_idle, i_clk, i_rst_n, r_done, r_state == S_IDLE, "result strobe outside idle")
    `CTH_ASSERT_SAME(a_walk_order, i_clk, i_rst_n, (r_state == S_WRD) || (r_state == S_WCMP), (r_scan <= r_j) && (r_j <= r_ref_count), "walk index outside window start and count")
    `CTH_ASSERT_SAME(a_ref_wr_room, i_clk, i_rst_n, o_ref_req.we, r_ref_count < cth_pkg::CNT_W'(cth_pkg::REF_DEPTH), "reference written into a full store")
    `CTH_ASSERT_SAME(a_bin_wr_state, i_clk, i_rst_n, o_bin_req.we, (r_state == S_CLR) || (r_state == S_EXEC) || (r_state == S_WINC), "bin written outside clear or update")

endmodule

// ----- sv/coincidence_time_histogram_unit.sv -----
// Top level of the coincidence time histogram unit: configuration registers,
// reference and bin stores, and the command sequencer. Depends on cth_pkg.
//
//  Channel    Signals                                          Handshake
//  command    i_func i_timestamp i_tick i_channel i_bin        start high, busy low
//  result     o_value o_flag                                   o_done, one cycle
//  config     i_cfg_idx i_cfg_data                             i_cfg_we
//
// After reset the 16384 bin entries (CHANNELS * BINS) are swept to zero, one
// entry a cycle, busy high. Clear refs, restart scan, clear bin and unused codes
// end in the execute state; load ref adds a write state, read bin a wait state.
// A pulse reads, subtracts and compares each reference, updates the in-range
// bin of each hit, and stops below the window or at the store's end. o_done
// strobes the result in the first cycle with busy low; it cannot be held off.
module coincidence_time_histogram_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cth_pkg::FUNC_W-1:0]       i_func,
    input  logic [cth_pkg::TS_W-1:0]         i_timestamp,
    input  logic [cth_pkg::TICK_W-1:0]       i_tick,
    input  logic [cth_pkg::CH_W-1:0]         i_channel,
    input  logic [cth_pkg::BIN_W-1:0]        i_bin,
    output logic                             o_done,
    output logic [cth_pkg::VAL_W-1:0]        o_value,
    output logic                             o_flag,
    input  logic                             i_cfg_we,
    input  logic [cth_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cth_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    cth_pkg::t_cfg                    r_cfg, n_cfg;
    cth_pkg::t_ref_req                ref_req;
    cth_pkg::t_bin_req                bin_req;
    logic [cth_pkg::T_W-1:0]          ref_rdata;
    logic [cth_pkg::VAL_W-1:0]        bin_rdata;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (cth_pkg::t_cfg_idx'(i_cfg_idx))
                cth_pkg::CFG_REF_TICK:  n_cfg.ref_tick    = i_cfg_data[cth_pkg::TICK_W-1:0];
                cth_pkg::CFG_WIN_LOW:   n_cfg.window_low  = i_cfg_data[cth_pkg::WIN_W-1:0];
                cth_pkg::CFG_WIN_HIGH:  n_cfg.window_high = i_cfg_data[cth_pkg::WIN_W-1:0];
                cth_pkg::CFG_BIN_SHIFT: n_cfg.bin_shift   = i_cfg_data[cth_pkg::SHIFT_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_tick    <= cth_pkg::REF_TICK_RST;
            r_cfg.window_low  <= cth_pkg::WIN_LOW_RST;
            r_cfg.window_high <= cth_pkg::WIN_HIGH_RST;
            r_cfg.bin_shift   <= cth_pkg::BIN_SHIFT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    cth_ram #(
        .DEPTH (cth_pkg::REF_DEPTH),
        .WIDTH (cth_pkg::T_W)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_req.we),
        .i_waddr (ref_req.addr),
        .i_wdata (ref_req.wdata),
        .i_re    (ref_req.re),
        .i_raddr (ref_req.addr),
        .o_rdata (ref_rdata)
    );

    cth_ram #(
        .DEPTH (cth_pkg::BIN_MEM_DEPTH),
        .WIDTH (cth_pkg::VAL_W)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_req.we),
        .i_waddr (bin_req.addr),
        .i_wdata (bin_req.wdata),
        .i_re    (bin_req.re),
        .i_raddr (bin_req.addr),
        .o_rdata (bin_rdata)
    );

    cth_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_func      (i_func),
        .i_timestamp (i_timestamp),
        .i_tick      (i_tick),
        .i_channel   (i_channel),
        .i_bin       (i_bin),
        .i_cfg       (r_cfg),
        .o_ref_req   (ref_req),
        .i_ref_rdata (ref_rdata),
        .o_bin_req   (bin_req),
        .i_bin_rdata (bin_rdata),
        .o_done      (o_done),
        .o_value     (o_value),
        .o_flag      (o_flag)
    );

endmodule
